@@ sv/ptc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the pressure and temperature compensation pipeline.
package ptc_pkg;

   // Configuration register indexes (paddr[4:3]).
   localparam logic [1:0] CSR_TEMP_CALIB   = 2'd0;
   localparam logic [1:0] CSR_PRES_CALIB_A = 2'd1;
   localparam logic [1:0] CSR_PRES_CALIB_B = 2'd2;
   localparam logic [1:0] CSR_PRES_CALIB_C = 2'd3;

   // Divider geometry: signed numerator, signed denominator, quotient magnitude bits.
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 40;
   localparam int QUOT_BITS = 37;

   // Fixed constants of the compensation.
   localparam logic signed [25:0] V1_OFFSET  = 26'sd128000;
   localparam logic signed [63:0] NUM_LIMIT  = 64'sd9223372036854775807 / 3125;
   localparam logic signed [63:0] NUM_SCALE  = 64'sd3125;
   localparam logic signed [63:0] DIV_BIAS   = 64'sd140737488355328;
   localparam logic [20:0]        RAW_FULL   = 21'd1048576;
   localparam logic signed [40:0] PQ_MAX     = 41'sd67108863;

   // Sideband that rides along with each transaction through the divider.
   typedef struct packed {
      logic               zero_div;
      logic signed [15:0] temp;
   } ptc_tag_type;

endpackage

@@ sv/ptc_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with saturated signed quotient.
module ptc_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  logic signed [ptc_pkg::DIV_NUM_W-1:0]   in_num,
   input  logic signed [ptc_pkg::DIV_DEN_W-1:0]   in_den,
   input  ptc_pkg::ptc_tag_type                   in_tag,
   output logic                                   out_valid,
   output logic signed [ptc_pkg::QUOT_BITS:0]     out_quot,
   output ptc_pkg::ptc_tag_type                   out_tag
);

   localparam int NW = ptc_pkg::DIV_NUM_W - 1;
   localparam int DW = ptc_pkg::DIV_DEN_W;
   localparam int QB = ptc_pkg::QUOT_BITS;
   localparam int RW = DW + QB;
   localparam logic [QB-1:0] QLIM = QB'(1) << (QB - 1);

   logic [ptc_pkg::DIV_NUM_W-1:0] num_abs_in;
   logic [DW-1:0]                 den_abs_in;

   // magnitude stage
   logic                 a_valid_ff;
   logic [NW-1:0]        a_nmag_ff;
   logic [DW-1:0]        a_dmag_ff;
   logic                 a_neg_ff;
   ptc_pkg::ptc_tag_type a_tag_ff;

   // iteration stages; entry 0 is the overflow-check stage
   logic                 st_valid_ff [0:QB];
   logic [NW-1:0]        st_rem_ff   [0:QB];
   logic [QB-1:0]        st_q_ff     [0:QB];
   logic [DW-1:0]        st_den_ff   [0:QB];
   logic                 st_neg_ff   [0:QB];
   logic                 st_ovf_ff   [0:QB];
   ptc_pkg::ptc_tag_type st_tag_ff   [0:QB];

   logic [QB-1:0]        mag_in;
   logic                 o_valid_ff;
   logic signed [QB:0]   o_quot_ff;
   ptc_pkg::ptc_tag_type o_tag_ff;

   assign num_abs_in = in_num[ptc_pkg::DIV_NUM_W-1] ? 
                       ptc_pkg::DIV_NUM_W'(-in_num) : ptc_pkg::DIV_NUM_W'(in_num);
   assign den_abs_in = in_den[DW-1] ? DW'(-in_den) : DW'(in_den);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         st_valid_ff[0] <= 1'b0;
      end else if (en) begin
         a_valid_ff     <= in_valid;
         st_valid_ff[0] <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_nmag_ff    <= num_abs_in[NW-1:0];
         a_dmag_ff    <= den_abs_in;
         a_neg_ff     <= in_num[ptc_pkg::DIV_NUM_W-1] ^ in_den[DW-1];
         a_tag_ff     <= in_tag;
         st_rem_ff[0] <= a_nmag_ff;
         st_q_ff[0]   <= '0;
         st_den_ff[0] <= a_dmag_ff;
         st_neg_ff[0] <= a_neg_ff;
         st_ovf_ff[0] <= RW'(a_nmag_ff >> QB) >= RW'(a_dmag_ff);
         st_tag_ff[0] <= a_tag_ff;
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_step
      localparam int J = QB - 1 - k;
      logic [RW-1:0] dsh;
      logic [RW-1:0] diff;
      logic          take;

      assign dsh  = RW'(st_den_ff[k]) << J;
      assign take = RW'(st_rem_ff[k]) >= dsh;
      assign diff = RW'(st_rem_ff[k]) - dsh;

      always_ff @(posedge clock) begin
         if (reset) begin
            st_valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            st_valid_ff[k+1] <= st_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_rem_ff[k+1] <= take ? diff[NW-1:0] : st_rem_ff[k];
            st_q_ff[k+1]   <= st_q_ff[k] | (QB'(take) << J);
            st_den_ff[k+1] <= st_den_ff[k];
            st_neg_ff[k+1] <= st_neg_ff[k];
            st_ovf_ff[k+1] <= st_ovf_ff[k];
            st_tag_ff[k+1] <= st_tag_ff[k];
         end
      end
   end

   // saturate magnitude, then apply sign
   assign mag_in = (st_ovf_ff[QB] || (st_q_ff[QB] > QLIM)) ? QLIM : st_q_ff[QB];

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (en) begin
         o_valid_ff <= st_valid_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_quot_ff <= st_neg_ff[QB] ? -$signed({1'b0, mag_in}) : $signed({1'b0, mag_in});
         o_tag_ff  <= st_tag_ff[QB];
      end
   end

   assign out_valid = o_valid_ff;
   assign out_quot  = o_quot_ff;
   assign out_tag   = o_tag_ff;

endmodule

@@ sv/pressure_temperature_compensation_top.sv @@
`timescale 1ns / 1ps
// Top level of the barometric sensor compensation pipeline with its register port.
// Compensates one raw 20-bit temperature / pressure pair per transaction using twelve
// calibration words held in four registers (temp_calib at 0x00, pres_calib_a at 0x08,
// pres_calib_b at 0x10, pres_calib_c at 0x18; 64-bit data). Each transaction returns the
// temperature in 0.01 degC, the pressure in Pa as Q18.8 and a flag for a zero pressure
// divisor (pressure then reads 0). The block is a 56-stage pipeline: eleven stages form
// the fine temperature term and the pressure numerator and divisor, forty stages run the
// signed division, one quotient bit per iteration stage, and five stages apply the final
// correction terms and saturate. A new transaction enters every cycle unless the result
// side stalls. A stall on the result side freezes the whole pipeline and is passed
// straight back to the request side. Write the calibration only while no transaction is
// in flight.
module pressure_temperature_compensation_top (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [19:0]        req_raw_temperature,
   input  logic [19:0]        req_raw_pressure,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_temperature_centi,
   output logic [25:0]        rsp_pressure_q8,
   output logic               rsp_divide_fault,
   // register port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [63:0]        csr_pwdata,
   output logic [63:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int QB = ptc_pkg::QUOT_BITS;
   localparam logic signed [QB:0] QUOT_LIM = $signed({2'b00, {(QB-1){1'b0}}}) | 
                                             ((QB+1)'(1) << (QB - 1));

   // ---------------------------------------------------------------- registers
   logic [47:0]        temp_calib_ff;
   logic [63:0]        pres_calib_a_ff;
   logic [63:0]        pres_calib_b_ff;
   logic signed [15:0] pres_calib_c_ff;
   logic               csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff   <= '0;
         pres_calib_a_ff <= '0;
         pres_calib_b_ff <= '0;
         pres_calib_c_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[4:3])
            ptc_pkg::CSR_TEMP_CALIB:   temp_calib_ff   <= csr_pwdata[47:0];
            ptc_pkg::CSR_PRES_CALIB_A: pres_calib_a_ff <= csr_pwdata;
            ptc_pkg::CSR_PRES_CALIB_B: pres_calib_b_ff <= csr_pwdata;
            ptc_pkg::CSR_PRES_CALIB_C: pres_calib_c_ff <= $signed(csr_pwdata[15:0]);
            default:                   temp_calib_ff   <= temp_calib_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:3])
         ptc_pkg::CSR_TEMP_CALIB:   csr_prdata = {16'd0, temp_calib_ff};
         ptc_pkg::CSR_PRES_CALIB_A: csr_prdata = pres_calib_a_ff;
         ptc_pkg::CSR_PRES_CALIB_B: csr_prdata = pres_calib_b_ff;
         ptc_pkg::CSR_PRES_CALIB_C: csr_prdata = {48'd0, pres_calib_c_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   // Unpack the calibration words.
   logic [15:0]        t1;
   logic signed [15:0] t2, t3;
   logic [15:0]        p1;
   logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

   assign t1 = temp_calib_ff[47:32];
   assign t2 = $signed(temp_calib_ff[31:16]);
   assign t3 = $signed(temp_calib_ff[15:0]);
   assign p1 = pres_calib_a_ff[63:48];
   assign p2 = $signed(pres_calib_a_ff[47:32]);
   assign p3 = $signed(pres_calib_a_ff[31:16]);
   assign p4 = $signed(pres_calib_a_ff[15:0]);
   assign p5 = $signed(pres_calib_b_ff[63:48]);
   assign p6 = $signed(pres_calib_b_ff[47:32]);
   assign p7 = $signed(pres_calib_b_ff[31:16]);
   assign p8 = $signed(pres_calib_b_ff[15:0]);
   assign p9 = pres_calib_c_ff;

   // ---------------------------------------------------------------- flow control
   // Advance every stage together unless a finished result is held by the sink.
   logic adv;
   logic rsp_valid_ff;

   assign adv       = ~(rsp_valid_ff & rsp_stall);
   assign req_stall = ~adv;

   // ---------------------------------------------------------------- front stages
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;
   logic s7_valid_ff, s8_valid_ff, s9_valid_ff, s10_valid_ff, s11_valid_ff;

   logic signed [18:0] s1_ta_ff;
   logic signed [17:0] s1_d_ff;
   logic [19:0]        s1_rp_ff;
   logic signed [34:0] s2_aprod_ff;
   logic [32:0]        s2_dsq_ff;
   logic [19:0]        s2_rp_ff;
   logic signed [23:0] s3_a_ff;
   logic signed [37:0] s3_bprod_ff;
   logic [19:0]        s3_rp_ff;
   logic signed [24:0] s4_fine_ff;
   logic [19:0]        s4_rp_ff;
   logic signed [15:0] s5_tc_ff;
   logic signed [25:0] s5_v1_ff;
   logic [19:0]        s5_rp_ff;
   logic signed [15:0] s6_tc_ff;
   logic signed [51:0] s6_v1sq_ff;
   logic signed [41:0] s6_v1p5_ff, s6_v1p2_ff;
   logic [19:0]        s6_rp_ff;
   logic signed [15:0] s7_tc_ff;
   logic signed [63:0] s7_m6_ff, s7_m3_ff;
   logic signed [41:0] s7_v1p5_ff, s7_v1p2_ff;
   logic [19:0]        s7_rp_ff;
   logic signed [15:0] s8_tc_ff;
   logic signed [63:0] s8_v2_ff, s8_v1_ff;
   logic [19:0]        s8_rp_ff;
   logic signed [15:0] s9_tc_ff;
   logic signed [30:0] s9_hi_ff;
   logic [32:0]        s9_lo_ff;
   logic signed [63:0] s9_num_ff;
   logic signed [15:0] s10_tc_ff;
   logic signed [47:0] s10_hp_ff;
   logic [48:0]        s10_lp_ff;
   logic signed [63:0] s10_num_ff;
   logic signed [15:0] s11_tc_ff;
   logic signed [39:0] s11_div_ff;
   logic signed [63:0] s11_num_ff;

   logic signed [35:0] dsq_in;
   logic signed [27:0] tscaled_in;
   logic signed [15:0] tc_in;
   logic signed [63:0] bias_in;
   logic [20:0]        rinv_in;
   logic signed [63:0] num_in;

   assign dsq_in     = 36'(s1_d_ff) * 36'(s1_d_ff);
   assign tscaled_in = (28'(s4_fine_ff) * 28'sd5 + 28'sd128) >>> 8;
   assign tc_in      = (tscaled_in > 28'sd32767)  ? 16'sd32767  :
                       (tscaled_in < -28'sd32768) ? -16'sd32768 : 16'(tscaled_in);
   assign bias_in    = ptc_pkg::DIV_BIAS + s8_v1_ff;
   assign rinv_in    = ptc_pkg::RAW_FULL - {1'b0, s8_rp_ff};
   assign num_in     = (s9_num_ff > ptc_pkg::NUM_LIMIT)  ? ptc_pkg::NUM_LIMIT  :
                       (s9_num_ff < -ptc_pkg::NUM_LIMIT) ? -ptc_pkg::NUM_LIMIT : s9_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
         s11_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= s7_valid_ff;
         s9_valid_ff  <= s8_valid_ff;
         s10_valid_ff <= s9_valid_ff;
         s11_valid_ff <= s10_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // Stage 1: offsets of the raw temperature against T1.
         s1_ta_ff    <= $signed({2'b00, req_raw_temperature[19:3]}) - $signed({2'b00, t1, 1'b0});
         s1_d_ff     <= $signed({2'b00, req_raw_temperature[19:4]}) - $signed({2'b00, t1});
         s1_rp_ff    <= req_raw_pressure;
         // Stage 2: linear and square products.
         s2_aprod_ff <= 35'(s1_ta_ff) * 35'(t2);
         s2_dsq_ff   <= dsq_in[32:0];
         s2_rp_ff    <= s1_rp_ff;
         // Stage 3: scale and apply T3.
         s3_a_ff     <= 24'(s2_aprod_ff >>> 11);
         s3_bprod_ff <= 38'($signed({1'b0, s2_dsq_ff[32:12]})) * 38'(t3);
         s3_rp_ff    <= s2_rp_ff;
         // Stage 4: fine temperature term.
         s4_fine_ff  <= 25'(s3_a_ff) + 25'(s3_bprod_ff >>> 14);
         s4_rp_ff    <= s3_rp_ff;
         // Stage 5: temperature result and pressure offset.
         s5_tc_ff    <= tc_in;
         s5_v1_ff    <= 26'(s4_fine_ff) - ptc_pkg::V1_OFFSET;
         s5_rp_ff    <= s4_rp_ff;
         // Stage 6: first-level products.
         s6_tc_ff    <= s5_tc_ff;
         s6_v1sq_ff  <= 52'(s5_v1_ff) * 52'(s5_v1_ff);
         s6_v1p5_ff  <= 42'(s5_v1_ff) * 42'(p5);
         s6_v1p2_ff  <= 42'(s5_v1_ff) * 42'(p2);
         s6_rp_ff    <= s5_rp_ff;
         // Stage 7: square terms with P6 and P3.
         s7_tc_ff    <= s6_tc_ff;
         s7_m6_ff    <= 64'(s6_v1sq_ff) * 64'(p6);
         s7_m3_ff    <= 64'(s6_v1sq_ff) * 64'(p3);
         s7_v1p5_ff  <= s6_v1p5_ff;
         s7_v1p2_ff  <= s6_v1p2_ff;
         s7_rp_ff    <= s6_rp_ff;
         // Stage 8: accumulate the numerator offset and the divisor term.
         s8_tc_ff    <= s7_tc_ff;
         s8_v2_ff    <= s7_m6_ff + (64'(s7_v1p5_ff) <<< 17) + (64'(p4) <<< 35);
         s8_v1_ff    <= (s7_m3_ff >>> 8) + (64'(s7_v1p2_ff) <<< 12);
         s8_rp_ff    <= s7_rp_ff;
         // Stage 9: split the biased divisor term; form the raw numerator.
         s9_tc_ff    <= s8_tc_ff;
         s9_hi_ff    <= 31'(bias_in >>> 33);
         s9_lo_ff    <= bias_in[32:0];
         s9_num_ff   <= $signed({12'd0, rinv_in, 31'd0}) - s8_v2_ff;
         // Stage 10: split product with P1; clamp the numerator.
         s10_tc_ff   <= s9_tc_ff;
         s10_hp_ff   <= 48'(s9_hi_ff) * 48'($signed({1'b0, p1}));
         s10_lp_ff   <= 49'(s9_lo_ff) * 49'(p1);
         s10_num_ff  <= num_in;
         // Stage 11: divisor and scaled numerator.
         s11_tc_ff   <= s10_tc_ff;
         s11_div_ff  <= 40'(s10_hp_ff) + 40'($signed({1'b0, s10_lp_ff[48:33]}));
         s11_num_ff  <= s10_num_ff * ptc_pkg::NUM_SCALE;
      end
   end

   // ---------------------------------------------------------------- divider
   ptc_pkg::ptc_tag_type div_tag_in;
   ptc_pkg::ptc_tag_type div_tag;
   logic                 div_valid;
   logic signed [QB:0]   div_quot;

   assign div_tag_in.zero_div = (s11_div_ff == '0);
   assign div_tag_in.temp     = s11_tc_ff;

   ptc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s11_valid_ff),
      .in_num    (s11_num_ff),
      .in_den    (s11_div_ff),
      .in_tag    (div_tag_in),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_tag   (div_tag)
   );

   // ---------------------------------------------------------------- back stages
   logic                 r1_valid_ff, r2_valid_ff, r3_valid_ff, r4_valid_ff;
   ptc_pkg::ptc_tag_type r1_tag_ff, r2_tag_ff, r3_tag_ff, r4_tag_ff;
   logic signed [QB:0]   r1_p_ff, r2_p_ff, r3_p_ff;
   logic signed [53:0]   r1_c8p_ff;
   logic signed [24:0]   r1_ps_ff;
   logic [46:0]          r2_pssq_ff;
   logic signed [34:0]   r2_c8_ff, r3_c8_ff;
   logic signed [63:0]   r3_c9p_ff;
   logic signed [39:0]   r4_sum_ff;

   logic signed [49:0]   pssq_in;
   logic signed [40:0]   r_in;
   logic [25:0]          pq_in;

   logic signed [15:0]   rsp_temp_ff;
   logic [25:0]          rsp_pq_ff;
   logic                 rsp_fault_ff;

   assign pssq_in = 50'(r1_ps_ff) * 50'(r1_ps_ff);
   assign r_in    = 41'(r4_sum_ff >>> 8) + (41'(p7) <<< 4);
   assign pq_in   = r4_tag_ff.zero_div        ? '0        :
                    (r_in < 41'sd0)           ? '0        :
                    (r_in > ptc_pkg::PQ_MAX)  ? '1        : r_in[25:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_valid_ff  <= 1'b0;
         r2_valid_ff  <= 1'b0;
         r3_valid_ff  <= 1'b0;
         r4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         r1_valid_ff  <= div_valid;
         r2_valid_ff  <= r1_valid_ff;
         r3_valid_ff  <= r2_valid_ff;
         r4_valid_ff  <= r3_valid_ff;
         rsp_valid_ff <= r4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // Take the quotient; start the P8 term and the reduced square operand.
         r1_tag_ff  <= div_tag;
         r1_p_ff    <= div_quot;
         r1_c8p_ff  <= 54'(div_quot) * 54'(p8);
         r1_ps_ff   <= 25'(div_quot >>> 13);
         // Square of the reduced quotient.
         r2_tag_ff  <= r1_tag_ff;
         r2_p_ff    <= r1_p_ff;
         r2_pssq_ff <= pssq_in[46:0];
         r2_c8_ff   <= 35'(r1_c8p_ff >>> 19);
         // Apply P9.
         r3_tag_ff  <= r2_tag_ff;
         r3_p_ff    <= r2_p_ff;
         r3_c9p_ff  <= 64'($signed({1'b0, r2_pssq_ff})) * 64'(p9);
         r3_c8_ff   <= r2_c8_ff;
         // Sum of quotient and corrections.
         r4_tag_ff  <= r3_tag_ff;
         r4_sum_ff  <= 40'(r3_p_ff) + 40'(r3_c9p_ff >>> 25) + 40'(r3_c8_ff);
         // Output register: add the P7 offset, saturate, drop on zero divisor.
         rsp_temp_ff  <= r4_tag_ff.temp;
         rsp_pq_ff    <= pq_in;
         rsp_fault_ff <= r4_tag_ff.zero_div;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temperature_centi = rsp_temp_ff;
   assign rsp_pressure_q8       = rsp_pq_ff;
   assign rsp_divide_fault      = rsp_fault_ff;

`ifndef SYNTHESIS
   // A zero divisor always reports zero pressure.
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fault_ff |-> rsp_pq_ff == '0)
      else $error("divide fault with nonzero pressure");

   // The divider quotient stays inside its saturation range.
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      div_valid |-> (div_quot <= QUOT_LIM) && (div_quot >= -QUOT_LIM))
      else $error("divider quotient out of range");

   // A held result freezes the pipeline: the divider output does not move.
   a_hold_div: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(div_valid) && $stable(div_quot))
      else $error("divider advanced under stall");

   // No result is presented right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result valid after reset");
`endif

endmodule
